[design/transition_graph_counter_macros.svh]
// Assertion macros shared by the transition graph counter modules
`ifndef TRANSITION_GRAPH_COUNTER_MACROS_SVH
`define TRANSITION_GRAPH_COUNTER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst
`define TGC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst
`define TGC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/tgc_pkg.sv]
// Shared types, codes and helpers for the transition graph counter
`timescale 1ns / 1ps
package tgc_pkg;

  localparam int DEF_NODE_SLOTS = 64;
  localparam int DEF_EDGE_SLOTS = 256;
  localparam int DEF_KEY_BITS   = 32;

  localparam int CNT_W      = 32;
  localparam int FIELD_W    = 32;
  localparam int OP_W       = 2;
  localparam int SLOT_W     = 8;
  localparam int SLOT_CMP_W = 16;

  localparam logic [OP_W-1:0] OP_RECORD    = 2'd0;
  localparam logic [OP_W-1:0] OP_READ_NODE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ_EDGE = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0]   node_count;
    logic [CNT_W-1:0]   edge_count;
    logic               node_new;
    logic               edge_new;
    logic               edge_counted;
    logic               node_dropped;
    logic               edge_dropped;
    logic               slot_used;
    logic [FIELD_W-1:0] slot_from_key;
    logic [FIELD_W-1:0] slot_to_key;
    logic [CNT_W-1:0]   slot_count;
  } result_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
  endfunction

endpackage

[design/tgc_ram.sv]
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module tgc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/tgc_engine.sv]
// Sequencer that scans, updates and reads the node and edge memories
`timescale 1ns / 1ps
`include "transition_graph_counter_macros.svh"
module tgc_engine
  import tgc_pkg::*;
#(
  parameter int NODE_SLOTS = DEF_NODE_SLOTS,
  parameter int EDGE_SLOTS = DEF_EDGE_SLOTS,
  parameter int KEY_BITS   = DEF_KEY_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   operation,
  input  logic [FIELD_W-1:0] key,
  input  logic [SLOT_W-1:0] slot,
  output logic              res_valid,
  input  logic              res_ready,
  output result_t           res
);

  localparam int NAW = $clog2(NODE_SLOTS);
  localparam int EAW = $clog2(EDGE_SLOTS);
  localparam int NFW = $clog2(NODE_SLOTS + 1);
  localparam int EFW = $clog2(EDGE_SLOTS + 1);
  localparam int NW  = KEY_BITS + CNT_W;
  localparam int EW  = 2 * KEY_BITS + CNT_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EISSUE = 3'd1;
  localparam logic [2:0] S_ESCAN  = 3'd2;
  localparam logic [2:0] S_NISSUE = 3'd3;
  localparam logic [2:0] S_NSCAN  = 3'd4;
  localparam logic [2:0] S_RISSUE = 3'd5;
  localparam logic [2:0] S_RDATA  = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]          state, state_next;
  logic [OP_W-1:0]     op_q, op_next;
  logic [KEY_BITS-1:0] key_q, key_next;
  logic [SLOT_W-1:0]   slot_q, slot_next;
  logic [KEY_BITS-1:0] prev_key, prev_key_next;
  logic                seen_any, seen_any_next;
  logic [NFW-1:0]      node_fill, node_fill_next;
  logic [EFW-1:0]      edge_fill, edge_fill_next;
  logic [NAW-1:0]      n_idx, n_idx_next;
  logic [EAW-1:0]      e_idx, e_idx_next;
  result_t             res_next;

  logic                n_we, e_we;
  logic [NAW-1:0]      n_waddr, n_raddr;
  logic [EAW-1:0]      e_waddr, e_raddr;
  logic [NW-1:0]       n_wdata, n_rdata;
  logic [EW-1:0]       e_wdata, e_rdata;
  logic [KEY_BITS-1:0] n_rkey, e_rsrc, e_rtgt;
  logic [CNT_W-1:0]    n_rcnt, e_rcnt;
  logic                n_hit, e_hit, n_last, e_last, n_miss, e_miss;
  logic [SLOT_CMP_W-1:0] slot_w;

  tgc_ram #(.WIDTH(NW), .DEPTH(NODE_SLOTS)) u_node_ram (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_waddr),
    .wdata (n_wdata),
    .raddr (n_raddr),
    .rdata (n_rdata)
  );

  tgc_ram #(.WIDTH(EW), .DEPTH(EDGE_SLOTS)) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  assign n_rkey = n_rdata[CNT_W +: KEY_BITS];
  assign n_rcnt = n_rdata[CNT_W-1:0];
  assign e_rsrc = e_rdata[CNT_W + KEY_BITS +: KEY_BITS];
  assign e_rtgt = e_rdata[CNT_W +: KEY_BITS];
  assign e_rcnt = e_rdata[CNT_W-1:0];

  assign n_hit  = (n_rkey == key_q);
  assign e_hit  = (e_rsrc == prev_key) && (e_rtgt == key_q);
  assign n_last = (NFW'(n_idx) + NFW'(1)) == node_fill;
  assign e_last = (EFW'(e_idx) + EFW'(1)) == edge_fill;
  assign slot_w = SLOT_CMP_W'(slot_q);

  assign in_stall  = (state != S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    state_next     = state;
    op_next        = op_q;
    key_next       = key_q;
    slot_next      = slot_q;
    prev_key_next  = prev_key;
    seen_any_next  = seen_any;
    node_fill_next = node_fill;
    edge_fill_next = edge_fill;
    n_idx_next     = n_idx;
    e_idx_next     = e_idx;
    res_next       = res;
    n_we           = 1'b0;
    e_we           = 1'b0;
    n_waddr        = n_idx;
    e_waddr        = e_idx;
    n_wdata        = {key_q, sat_inc(n_rcnt)};
    e_wdata        = {prev_key, key_q, sat_inc(e_rcnt)};
    n_raddr        = '0;
    e_raddr        = '0;
    n_miss         = 1'b0;
    e_miss         = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_next   = operation;
          key_next  = KEY_BITS'(key);
          slot_next = slot;
          res_next  = '0;
          unique case (operation) inside
            OP_RECORD:                 state_next = S_EISSUE;
            OP_READ_NODE, OP_READ_EDGE: state_next = S_RISSUE;
            default:                   state_next = S_DONE;
          endcase
        end
      end
      S_EISSUE: begin
        if (!seen_any) begin
          state_next = S_NISSUE;
        end else begin
          res_next.edge_counted = 1'b1;
          if (edge_fill == '0) begin
            e_miss     = 1'b1;
            state_next = S_NISSUE;
          end else begin
            e_idx_next = '0;
            state_next = S_ESCAN;
          end
        end
      end
      S_ESCAN: begin
        e_raddr = e_idx + 1'b1;
        if (e_hit) begin
          e_we                = 1'b1;
          res_next.edge_count = sat_inc(e_rcnt);
          state_next          = S_NISSUE;
        end else if (e_last) begin
          e_miss     = 1'b1;
          state_next = S_NISSUE;
        end else begin
          e_idx_next = e_idx + 1'b1;
        end
      end
      S_NISSUE: begin
        prev_key_next = key_q;
        seen_any_next = 1'b1;
        if (node_fill == '0) begin
          n_miss     = 1'b1;
          state_next = S_DONE;
        end else begin
          n_idx_next = '0;
          state_next = S_NSCAN;
        end
      end
      S_NSCAN: begin
        n_raddr = n_idx + 1'b1;
        if (n_hit) begin
          n_we                = 1'b1;
          res_next.node_count = sat_inc(n_rcnt);
          state_next          = S_DONE;
        end else if (n_last) begin
          n_miss     = 1'b1;
          state_next = S_DONE;
        end else begin
          n_idx_next = n_idx + 1'b1;
        end
      end
      S_RISSUE: begin
        n_raddr    = slot_w[NAW-1:0];
        e_raddr    = slot_w[EAW-1:0];
        state_next = S_RDATA;
      end
      S_RDATA: begin
        if (op_q == OP_READ_NODE) begin
          if (slot_w < SLOT_CMP_W'(node_fill)) begin
            res_next.slot_used     = 1'b1;
            res_next.slot_from_key = FIELD_W'(n_rkey);
            res_next.slot_count    = n_rcnt;
          end
        end else begin
          if (slot_w < SLOT_CMP_W'(edge_fill)) begin
            res_next.slot_used     = 1'b1;
            res_next.slot_from_key = FIELD_W'(e_rsrc);
            res_next.slot_to_key   = FIELD_W'(e_rtgt);
            res_next.slot_count    = e_rcnt;
          end
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (e_miss) begin
      if (edge_fill < EFW'(EDGE_SLOTS)) begin
        e_we                = 1'b1;
        e_waddr             = edge_fill[EAW-1:0];
        e_wdata             = {prev_key, key_q, CNT_W'(1)};
        edge_fill_next      = edge_fill + 1'b1;
        res_next.edge_new   = 1'b1;
        res_next.edge_count = CNT_W'(1);
      end else begin
        res_next.edge_dropped = 1'b1;
      end
    end

    if (n_miss) begin
      if (node_fill < NFW'(NODE_SLOTS)) begin
        n_we                = 1'b1;
        n_waddr             = node_fill[NAW-1:0];
        n_wdata             = {key_q, {CNT_W{1'b0}}};
        node_fill_next      = node_fill + 1'b1;
        res_next.node_new   = 1'b1;
        res_next.node_count = '0;
      end else begin
        res_next.node_dropped = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      seen_any  <= 1'b0;
      node_fill <= '0;
      edge_fill <= '0;
      prev_key  <= '0;
    end else begin
      state     <= state_next;
      seen_any  <= seen_any_next;
      node_fill <= node_fill_next;
      edge_fill <= edge_fill_next;
      prev_key  <= prev_key_next;
    end
    op_q   <= op_next;
    key_q  <= key_next;
    slot_q <= slot_next;
    n_idx  <= n_idx_next;
    e_idx  <= e_idx_next;
    res    <= res_next;
  end

  `TGC_ASSERT_IMP(a_escan_range, state == S_ESCAN, EFW'(e_idx) < edge_fill,
    "edge scan index beyond fill")
  `TGC_ASSERT_IMP(a_nscan_range, state == S_NSCAN, NFW'(n_idx) < node_fill,
    "node scan index beyond fill")
  `TGC_ASSERT_NXT(a_accept_busy, in_valid && !in_stall, state != S_IDLE,
    "accepted transaction left engine idle")
  `TGC_ASSERT_IMP(a_fill_bound, 1'b1,
    (node_fill <= NFW'(NODE_SLOTS)) && (edge_fill <= EFW'(EDGE_SLOTS)),
    "fill count beyond table size")

endmodule

[design/transition_graph_counter.sv]
// Transition graph counter: record and read engine with an output register
//
// Input channel (in_valid / in_stall): one transaction carries operation, key
// and slot. Record transactions count the edge from the previous key and the
// visit of the new key; read transactions return one node or edge slot.
// Output channel (out_valid / out_stall): one result transaction per input.
// A record scans the edge memory and then the node memory, one entry per cycle,
// up to the stored edge and node entries, and then presents its result. A read
// issues the slot address, then captures the read data and presents it; an
// unknown operation goes straight from acceptance to its result. One transaction
// is in the engine at a time; the next one is taken while a finished result
// still waits in the output register.
// Reset (rst, synchronous) empties both tables, clears the previous key and
// drops any pending result. When the receiver stalls, the result holds in the
// output register and the engine holds its next result until the register
// frees, stalling the input channel meanwhile.
`timescale 1ns / 1ps
`include "transition_graph_counter_macros.svh"
module transition_graph_counter
  import tgc_pkg::*;
#(
  parameter int NODE_SLOTS = DEF_NODE_SLOTS,
  parameter int EDGE_SLOTS = DEF_EDGE_SLOTS,
  parameter int KEY_BITS   = DEF_KEY_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OP_W-1:0]    operation,
  input  logic [FIELD_W-1:0] key,
  input  logic [SLOT_W-1:0]  slot,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CNT_W-1:0]   node_count,
  output logic [CNT_W-1:0]   edge_count,
  output logic               node_new,
  output logic               edge_new,
  output logic               edge_counted,
  output logic               node_dropped,
  output logic               edge_dropped,
  output logic               slot_used,
  output logic [FIELD_W-1:0] slot_from_key,
  output logic [FIELD_W-1:0] slot_to_key,
  output logic [CNT_W-1:0]   slot_count
);

  logic    res_valid;
  logic    res_ready;
  result_t res;
  result_t out_res;

  tgc_engine #(
    .NODE_SLOTS (NODE_SLOTS),
    .EDGE_SLOTS (EDGE_SLOTS),
    .KEY_BITS   (KEY_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .key       (key),
    .slot      (slot),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign node_count    = out_res.node_count;
  assign edge_count    = out_res.edge_count;
  assign node_new      = out_res.node_new;
  assign edge_new      = out_res.edge_new;
  assign edge_counted  = out_res.edge_counted;
  assign node_dropped  = out_res.node_dropped;
  assign edge_dropped  = out_res.edge_dropped;
  assign slot_used     = out_res.slot_used;
  assign slot_from_key = out_res.slot_from_key;
  assign slot_to_key   = out_res.slot_to_key;
  assign slot_count    = out_res.slot_count;

  `TGC_ASSERT_NXT(a_load_shows, res_valid && res_ready, out_valid,
    "loaded result not presented")
  `TGC_ASSERT_NXT(a_pending_holds, res_valid && out_valid && out_stall, res_valid,
    "pending result lost while output stalled")
  `TGC_ASSERT_IMP(a_idle_no_result, !in_stall, !res_valid,
    "engine ready with a result pending")

endmodule

[verif/tb_transition_graph_counter.sv]
// Self-checking testbench for the transition graph counter: directed table, random traffic
`timescale 1ns / 1ps
module tb_transition_graph_counter;
  import tgc_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 7;
  localparam int NODE_SLOTS   = DEF_NODE_SLOTS;
  localparam int EDGE_SLOTS   = DEF_EDGE_SLOTS;
  localparam int RANDOM_ITEMS = 1600;
  localparam int HOLD_CYCLES  = 3000;
  localparam int TAIL_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 4_000_000;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [FIELD_W-1:0] k;
    logic [SLOT_W-1:0]  s;
    bit                 pinned;
    result_t            want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [OP_W-1:0]    operation;
  logic [FIELD_W-1:0] key;
  logic [SLOT_W-1:0]  slot;
  logic               out_valid;
  logic               out_stall;
  logic [CNT_W-1:0]   node_count;
  logic [CNT_W-1:0]   edge_count;
  logic               node_new;
  logic               edge_new;
  logic               edge_counted;
  logic               node_dropped;
  logic               edge_dropped;
  logic               slot_used;
  logic [FIELD_W-1:0] slot_from_key;
  logic [FIELD_W-1:0] slot_to_key;
  logic [CNT_W-1:0]   slot_count;

  logic    pin_on;
  result_t pin_res;

  // graph mirror: tables fill in order, so a slot is live when below its fill count
  logic [FIELD_W-1:0] nd_key [NODE_SLOTS];
  logic [CNT_W-1:0]   nd_cnt [NODE_SLOTS];
  logic [FIELD_W-1:0] ed_src [EDGE_SLOTS];
  logic [FIELD_W-1:0] ed_dst [EDGE_SLOTS];
  logic [CNT_W-1:0]   ed_cnt [EDGE_SLOTS];
  int                 nodes_stored = 0;
  int                 edges_stored = 0;
  logic [FIELD_W-1:0] prev_key = '0;
  bit                 have_prev = 1'b0;

  logic [FIELD_W-1:0] hot_keys [8];
  logic [FIELD_W-1:0] warm_keys [100];

  result_t   outcomes_due [$];
  stim_row_t directed_rows [$];
  result_t   want_now;
  result_t   got_now;

  int  mismatches = 0;
  int  results_seen = 0;
  int  records = 0;
  int  node_reads = 0;
  int  edge_reads = 0;
  int  unused_ops = 0;
  int  node_drops = 0;
  int  edge_drops = 0;
  int  repeat_edges = 0;
  int  long_holds = 0;
  bit  long_hold_req = 1'b0;

  transition_graph_counter u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .key           (key),
    .slot          (slot),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .node_count    (node_count),
    .edge_count    (edge_count),
    .node_new      (node_new),
    .edge_new      (edge_new),
    .edge_counted  (edge_counted),
    .node_dropped  (node_dropped),
    .edge_dropped  (edge_dropped),
    .slot_used     (slot_used),
    .slot_from_key (slot_from_key),
    .slot_to_key   (slot_to_key),
    .slot_count    (slot_count)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [CNT_W-1:0] saturating_bump(input logic [CNT_W-1:0] c);
    return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
  endfunction

  // advance the graph mirror by one transaction and return its result
  function automatic result_t graph_outcome(input logic [OP_W-1:0] op,
                                            input logic [FIELD_W-1:0] k,
                                            input logic [SLOT_W-1:0] s);
    result_t r;
    int      hit;
    r = '0;
    hit = -1;
    case (op)
      OP_RECORD: begin
        if (have_prev) begin
          r.edge_counted = 1'b1;
          for (int i = 0; i < edges_stored; i++)
            if (hit < 0 && ed_src[i] == prev_key && ed_dst[i] == k) hit = i;
          if (hit >= 0) begin
            ed_cnt[hit] = saturating_bump(ed_cnt[hit]);
            r.edge_count = ed_cnt[hit];
            repeat_edges++;
          end else if (edges_stored < EDGE_SLOTS) begin
            ed_src[edges_stored] = prev_key;
            ed_dst[edges_stored] = k;
            ed_cnt[edges_stored] = 1;
            edges_stored++;
            r.edge_count = 1;
            r.edge_new = 1'b1;
          end else begin
            r.edge_dropped = 1'b1;
            edge_drops++;
          end
        end
        prev_key = k;
        have_prev = 1'b1;
        hit = -1;
        for (int i = 0; i < nodes_stored; i++)
          if (hit < 0 && nd_key[i] == k) hit = i;
        if (hit >= 0) begin
          nd_cnt[hit] = saturating_bump(nd_cnt[hit]);
          r.node_count = nd_cnt[hit];
        end else if (nodes_stored < NODE_SLOTS) begin
          nd_key[nodes_stored] = k;
          nd_cnt[nodes_stored] = '0;
          nodes_stored++;
          r.node_new = 1'b1;
        end else begin
          r.node_dropped = 1'b1;
          node_drops++;
        end
      end
      OP_READ_NODE: begin
        if (int'(s) < nodes_stored) begin
          r.slot_used = 1'b1;
          r.slot_from_key = nd_key[s];
          r.slot_count = nd_cnt[s];
        end
      end
      OP_READ_EDGE: begin
        if (int'(s) < edges_stored) begin
          r.slot_used = 1'b1;
          r.slot_from_key = ed_src[s];
          r.slot_to_key = ed_dst[s];
          r.slot_count = ed_cnt[s];
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic result_t rec_res(input logic [CNT_W-1:0] nc, input logic [CNT_W-1:0] ec,
                                      input logic nn, input logic en, input logic counted);
    result_t r;
    r = '0;
    r.node_count = nc;
    r.edge_count = ec;
    r.node_new = nn;
    r.edge_new = en;
    r.edge_counted = counted;
    return r;
  endfunction

  function automatic result_t slot_res(input logic used, input logic [FIELD_W-1:0] from_k,
                                       input logic [FIELD_W-1:0] to_k,
                                       input logic [CNT_W-1:0] cnt);
    result_t r;
    r = '0;
    r.slot_used = used;
    r.slot_from_key = from_k;
    r.slot_to_key = to_k;
    r.slot_count = cnt;
    return r;
  endfunction

  function automatic stim_row_t mk_row(input logic [OP_W-1:0] op, input logic [FIELD_W-1:0] k,
                                       input logic [SLOT_W-1:0] s, input bit pinned,
                                       input result_t want);
    stim_row_t row;
    row.op = op;
    row.k = k;
    row.s = s;
    row.pinned = pinned;
    row.want = want;
    return row;
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t row;
    int        pick;
    int        kp;
    row = mk_row(OP_RECORD, $urandom(), SLOT_W'($urandom_range(0, 255)), 1'b0, '0);
    pick = $urandom_range(0, 99);
    if (pick < 62) begin
      kp = $urandom_range(0, 99);
      if (kp < 55) row.k = hot_keys[$urandom_range(0, 7)];
      else if (kp < 82) row.k = warm_keys[$urandom_range(0, 99)];
    end else if (pick < 78) begin
      row.op = OP_READ_NODE;
      if ($urandom_range(0, 3) != 0) row.s = SLOT_W'($urandom_range(0, NODE_SLOTS - 1));
    end else if (pick < 95) begin
      row.op = OP_READ_EDGE;
    end else begin
      row.op = OP_UNUSED;
    end
    return row;
  endfunction

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 90);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch on result %0d, %s: got 0x%08h expected 0x%08h",
             results_seen, what, got, want);
  endtask

  task automatic check_outcome(input result_t got, input result_t want);
    if (got.node_count !== want.node_count)
      report_mismatch("node_count", got.node_count, want.node_count);
    if (got.edge_count !== want.edge_count)
      report_mismatch("edge_count", got.edge_count, want.edge_count);
    if (got.node_new !== want.node_new)
      report_mismatch("node_new", 32'(got.node_new), 32'(want.node_new));
    if (got.edge_new !== want.edge_new)
      report_mismatch("edge_new", 32'(got.edge_new), 32'(want.edge_new));
    if (got.edge_counted !== want.edge_counted)
      report_mismatch("edge_counted", 32'(got.edge_counted), 32'(want.edge_counted));
    if (got.node_dropped !== want.node_dropped)
      report_mismatch("node_dropped", 32'(got.node_dropped), 32'(want.node_dropped));
    if (got.edge_dropped !== want.edge_dropped)
      report_mismatch("edge_dropped", 32'(got.edge_dropped), 32'(want.edge_dropped));
    if (got.slot_used !== want.slot_used)
      report_mismatch("slot_used", 32'(got.slot_used), 32'(want.slot_used));
    if (got.slot_from_key !== want.slot_from_key)
      report_mismatch("slot_from_key", got.slot_from_key, want.slot_from_key);
    if (got.slot_to_key !== want.slot_to_key)
      report_mismatch("slot_to_key", got.slot_to_key, want.slot_to_key);
    if (got.slot_count !== want.slot_count)
      report_mismatch("slot_count", got.slot_count, want.slot_count);
  endtask

  task automatic offer(input stim_row_t row);
    in_valid <= 1'b1;
    operation <= row.op;
    key <= row.k;
    slot <= row.s;
    pin_on <= row.pinned;
    pin_res <= row.want;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_sender(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // predict on input transactions, check output transactions
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        want_now = graph_outcome(operation, key, slot);
        if (pin_on) want_now = pin_res;
        outcomes_due.push_back(want_now);
        case (operation)
          OP_RECORD: records++;
          OP_READ_NODE: node_reads++;
          OP_READ_EDGE: edge_reads++;
          default: unused_ops++;
        endcase
      end
      if (out_valid && !out_stall) begin
        got_now = '{node_count, edge_count, node_new, edge_new, edge_counted, node_dropped,
                    edge_dropped, slot_used, slot_from_key, slot_to_key, slot_count};
        if (outcomes_due.size() == 0) begin
          report_mismatch("result with nothing pending", 32'd0, 32'd0);
        end else begin
          check_outcome(got_now, outcomes_due.pop_front());
        end
        results_seen++;
      end
    end
  end

  // receiver: random stalls, calm stretches, and one long hold-off
  initial begin
    int held;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        long_holds++;
      end else if ($urandom_range(0, 1) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat (pick_idle() + 1) @(posedge clk);
      end
    end
  end

  initial begin
    int cycle_count;
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("timeout after %0d cycles, %0d results still pending",
             cycle_count, outcomes_due.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int calm_left;
    calm_left = 0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    operation <= OP_RECORD;
    key <= '0;
    slot <= '0;
    pin_on <= 1'b0;
    pin_res <= '0;
    foreach (hot_keys[i]) hot_keys[i] = $urandom();
    foreach (warm_keys[i]) warm_keys[i] = $urandom();

    directed_rows.push_back(mk_row(OP_READ_NODE, 32'h0, 8'd0, 1'b1, '0));
    directed_rows.push_back(mk_row(OP_READ_EDGE, 32'h0, 8'd0, 1'b1, '0));
    directed_rows.push_back(mk_row(OP_READ_NODE, 32'hFFFF_FFFF, 8'd255, 1'b1, '0));
    directed_rows.push_back(mk_row(OP_UNUSED, 32'hFFFF_FFFF, 8'd255, 1'b1, '0));
    directed_rows.push_back(mk_row(OP_RECORD, 32'h0, 8'd255, 1'b1,
                                   rec_res(32'd0, 32'd0, 1'b1, 1'b0, 1'b0)));
    directed_rows.push_back(mk_row(OP_RECORD, 32'hFFFF_FFFF, 8'd0, 1'b1,
                                   rec_res(32'd0, 32'd1, 1'b1, 1'b1, 1'b1)));
    directed_rows.push_back(mk_row(OP_RECORD, 32'h0, 8'd0, 1'b1,
                                   rec_res(32'd1, 32'd1, 1'b0, 1'b1, 1'b1)));
    directed_rows.push_back(mk_row(OP_RECORD, 32'hFFFF_FFFF, 8'd0, 1'b1,
                                   rec_res(32'd1, 32'd2, 1'b0, 1'b0, 1'b1)));
    directed_rows.push_back(mk_row(OP_RECORD, 32'hFFFF_FFFF, 8'd0, 1'b1,
                                   rec_res(32'd2, 32'd1, 1'b0, 1'b1, 1'b1)));
    directed_rows.push_back(mk_row(OP_READ_NODE, 32'hFFFF_FFFF, 8'd0, 1'b1,
                                   slot_res(1'b1, 32'h0, 32'h0, 32'd1)));
    directed_rows.push_back(mk_row(OP_READ_NODE, 32'h0, 8'd1, 1'b1,
                                   slot_res(1'b1, 32'hFFFF_FFFF, 32'h0, 32'd2)));
    directed_rows.push_back(mk_row(OP_READ_EDGE, 32'h0, 8'd0, 1'b1,
                                   slot_res(1'b1, 32'h0, 32'hFFFF_FFFF, 32'd2)));
    directed_rows.push_back(mk_row(OP_READ_EDGE, 32'h0, 8'd1, 1'b1,
                                   slot_res(1'b1, 32'hFFFF_FFFF, 32'h0, 32'd1)));
    directed_rows.push_back(mk_row(OP_READ_EDGE, 32'h0, 8'd2, 1'b1,
                                   slot_res(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1)));
    directed_rows.push_back(mk_row(OP_READ_NODE, 32'h0, 8'd63, 1'b1, '0));
    directed_rows.push_back(mk_row(OP_READ_NODE, 32'h0, 8'd64, 1'b1, '0));
    directed_rows.push_back(mk_row(OP_READ_EDGE, 32'h0, 8'd255, 1'b1, '0));
    directed_rows.push_back(mk_row(OP_READ_NODE, 32'h0, 8'd2, 1'b1, '0));
    directed_rows.push_back(mk_row(OP_UNUSED, 32'hA5A5_A5A5, 8'h5A, 1'b1, '0));
    directed_rows.push_back(mk_row(OP_RECORD, 32'hA5A5_A5A5, 8'hA5, 1'b0, '0));
    directed_rows.push_back(mk_row(OP_RECORD, 32'h5A5A_5A5A, 8'h5A, 1'b0, '0));
    directed_rows.push_back(mk_row(OP_RECORD, 32'hA5A5_A5A5, 8'h00, 1'b0, '0));
    directed_rows.push_back(mk_row(OP_RECORD, 32'h5A5A_5A5A, 8'h00, 1'b0, '0));
    directed_rows.push_back(mk_row(OP_READ_EDGE, 32'h1234_5678, 8'd3, 1'b0, '0));
    directed_rows.push_back(mk_row(OP_READ_NODE, 32'h8765_4321, 8'd3, 1'b0, '0));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      offer(directed_rows[i]);
      idle_sender(pick_idle());
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 300) long_hold_req = 1'b1;
      if (n == 1000) begin
        // drain: hold off until every pending result is back
        in_valid <= 1'b0;
        do @(posedge clk); while (outcomes_due.size() != 0);
      end
      offer(random_row());
      if (calm_left > 0) begin
        calm_left--;
      end else if ($urandom_range(0, 99) < 3) begin
        calm_left = 40;
      end else begin
        idle_sender(pick_idle());
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (outcomes_due.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d records, %0d node reads, %0d edge reads, %0d unused ops; %0d results",
             records, node_reads, edge_reads, unused_ops, results_seen);
    $display("graph held %0d nodes, %0d edges; %0d node drops, %0d edge drops, %0d repeat edges",
             nodes_stored, edges_stored, node_drops, edge_drops, repeat_edges);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/tgc_pkg.sv
design/tgc_ram.sv
design/tgc_engine.sv
design/transition_graph_counter.sv
verif/tb_transition_graph_counter.sv
